@@ rtl/imufp_pkg.sv @@
package imufp_pkg;

    // Frame layout: header, type, three axes, temperature, checksum.
    localparam int unsigned FRAME_LEN = 11;
    localparam int unsigned CNT_W     = 4;

    localparam logic [7:0] HDR_BYTE  = 8'h55;
    localparam logic [7:0] TYPE_ACC  = 8'h51;
    localparam logic [7:0] TYPE_ANG  = 8'h53;

    // Scale factors, all giving signed Q.8 results.
    localparam logic signed [31:0] ACC_GAIN  = 32'sd20070;
    localparam int unsigned        ACC_SHIFT = 16;
    localparam logic signed [21:0] ANG_GAIN  = 22'sd45;
    localparam int unsigned        ANG_SHIFT = 5;
    localparam logic signed [31:0] TMP_GAIN  = 32'sd49345;
    localparam int unsigned        TMP_SHIFT = 16;
    localparam logic signed [15:0] TMP_OFFS  = 16'sd5376;

    typedef enum logic [1:0] {
        KIND_ACC   = 2'd0,
        KIND_ANG   = 2'd1,
        KIND_OTHER = 2'd2
    } t_kind;

    // One complete frame as raw little-endian samples.
    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic signed [15:0] raw_z;
        logic signed [15:0] raw_t;
    } t_frame;

endpackage

@@ rtl/imufp_if.sv @@
// Received byte channel.
interface imufp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// Decoded frame channel.
interface imufp_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         frame_kind;
    logic signed [16:0] axis_x;
    logic signed [16:0] axis_y;
    logic signed [16:0] axis_z;
    logic signed [15:0] temperature;

    modport source (output valid, output frame_kind, output axis_x, output axis_y,
                    output axis_z, output temperature, input ready);
    modport sink (input valid, input frame_kind, input axis_x, input axis_y,
                  input axis_z, input temperature, output ready);
endinterface

@@ rtl/imu_frame_parser.sv @@
// IMU frame parser.
// i_byte carries one received serial byte per beat. Bytes are dropped until a
// 0x55 header arrives; the header and the next ten bytes form one frame.
// o_res carries one beat per complete frame: the frame kind (acceleration,
// angle or other) and three axes plus temperature in signed Q.8. Frames of
// another type report zeros. The checksum byte is not checked, and a header
// byte inside a frame is taken as data.
// Throughput: one byte per cycle while i_byte.ready is high. The frame is
// captured into a frame register when its last byte is accepted; the scaling
// multiplies sit between that register and the output register, which takes
// the scaled result once it is empty or its beat is taken.
// Reset (synchronous, active low) empties the byte counter and both pipeline
// registers, so the parser starts by hunting for a header.
// When the receiver holds o_res.ready low the result waits in the output
// register; a second frame can wait in the frame register, and bytes keep
// being accepted until both are full, after which i_byte.ready falls.
module imu_frame_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    imufp_byte_if.sink          i_byte,
    imufp_res_if.source         o_res
);

    logic [7:0]                   r_store [imufp_pkg::FRAME_LEN - 1];
    logic [imufp_pkg::CNT_W-1:0]  r_count;
    logic                         r_frm_valid;
    imufp_pkg::t_frame            r_frm;
    imufp_pkg::t_frame            n_frm;
    logic                         r_out_valid;
    logic [1:0]                   r_kind;
    logic signed [16:0]           r_ax;
    logic signed [16:0]           r_ay;
    logic signed [16:0]           r_az;
    logic signed [15:0]           r_tmp;
    logic signed [16:0]           n_ax;
    logic signed [16:0]           n_ay;
    logic signed [16:0]           n_az;
    logic signed [15:0]           n_tmp;

    logic in_fire;
    logic out_load;
    logic frm_load;
    logic frame_done;

    // Pipeline flow control: each register loads when it is empty or drains.
    assign out_load     = !r_out_valid || o_res.ready;
    assign frm_load     = !r_frm_valid || out_load;
    assign i_byte.ready = frm_load;
    assign in_fire      = i_byte.valid && i_byte.ready;
    assign frame_done   = in_fire &&
                          (r_count == imufp_pkg::CNT_W'(imufp_pkg::FRAME_LEN - 1));

    // Byte counter and frame store; a non-header first byte is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (in_fire) begin
            if (r_count == '0) begin
                if (i_byte.rx_byte == imufp_pkg::HDR_BYTE) begin
                    r_count <= r_count + 1'b1;
                end
            end else if (frame_done) begin
                r_count <= '0;
            end else begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && !frame_done) begin
            r_store[r_count] <= i_byte.rx_byte;
        end
    end

    // Frame decode from the stored bytes; the checksum is never looked at.
    always_comb begin
        n_frm.raw_x = {r_store[3], r_store[2]};
        n_frm.raw_y = {r_store[5], r_store[4]};
        n_frm.raw_z = {r_store[7], r_store[6]};
        n_frm.raw_t = {r_store[9], r_store[8]};
        case (r_store[1])
            imufp_pkg::TYPE_ACC: n_frm.kind = imufp_pkg::KIND_ACC;
            imufp_pkg::TYPE_ANG: n_frm.kind = imufp_pkg::KIND_ANG;
            default:             n_frm.kind = imufp_pkg::KIND_OTHER;
        endcase
    end

    // Frame register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frm_valid <= 1'b0;
        end else if (frm_load) begin
            r_frm_valid <= frame_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_done) begin
            r_frm <= n_frm;
        end
    end

    // Scaling of one sample to Q.8 for acceleration or angle.
    function automatic logic signed [16:0] scale_axis(input imufp_pkg::t_kind kind,
                                                      input logic signed [15:0] raw);
        logic signed [31:0] acc_p;
        logic signed [21:0] ang_p;
        acc_p = 32'(raw) * imufp_pkg::ACC_GAIN;
        ang_p = 22'(raw) * imufp_pkg::ANG_GAIN;
        case (kind)
            imufp_pkg::KIND_ACC: scale_axis = 17'(acc_p >>> imufp_pkg::ACC_SHIFT);
            imufp_pkg::KIND_ANG: scale_axis = 17'(ang_p >>> imufp_pkg::ANG_SHIFT);
            default:             scale_axis = '0;
        endcase
    endfunction

    // Three axes and temperature are scaled side by side.
    always_comb begin
        logic signed [31:0] tmp_p;
        tmp_p = 32'(r_frm.raw_t) * imufp_pkg::TMP_GAIN;
        n_ax  = scale_axis(r_frm.kind, r_frm.raw_x);
        n_ay  = scale_axis(r_frm.kind, r_frm.raw_y);
        n_az  = scale_axis(r_frm.kind, r_frm.raw_z);
        if (r_frm.kind == imufp_pkg::KIND_OTHER) begin
            n_tmp = '0;
        end else begin
            n_tmp = 16'(tmp_p >>> imufp_pkg::TMP_SHIFT) + imufp_pkg::TMP_OFFS;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_frm_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_frm_valid) begin
            r_kind <= r_frm.kind;
            r_ax   <= n_ax;
            r_ay   <= n_ay;
            r_az   <= n_az;
            r_tmp  <= n_tmp;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.frame_kind  = r_kind;
    assign o_res.axis_x      = r_ax;
    assign o_res.axis_y      = r_ay;
    assign o_res.axis_z      = r_az;
    assign o_res.temperature = r_tmp;

endmodule

@@ rtl/imufp_checker.sv @@
module imufp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [1:0]         i_kind,
    input logic signed [16:0] i_ax,
    input logic signed [16:0] i_ay,
    input logic signed [16:0] i_az,
    input logic signed [15:0] i_tmp
);

    // Reset leaves no result beat pending.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result beat valid after reset");

    // A stalled result beat stays offered.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat withdrawn while stalled");

    // A stalled result beat keeps its payload.
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_kind) && $stable(i_ax) && $stable(i_ay) && $stable(i_az)
            && $stable(i_tmp))
        else $error("result payload changed while stalled");

    // Frames of an unknown type report all zeros.
    a_other_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == imufp_pkg::KIND_OTHER |->
            i_ax == '0 && i_ay == '0 && i_az == '0 && i_tmp == '0)
        else $error("unknown frame type with non-zero values");

endmodule

bind imu_frame_parser imufp_checker u_imufp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_kind      (o_res.frame_kind),
    .i_ax        (o_res.axis_x),
    .i_ay        (o_res.axis_y),
    .i_az        (o_res.axis_z),
    .i_tmp       (o_res.temperature)
);
